// ===== hw/rtl/rigid_pose_quaternion_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Rigid pose quaternion unit - assertion macros
// Shared property wrappers for the clocked checks of the pose unit.
// ----------------------------------------------------------------------------
`ifndef RIGID_POSE_QUATERNION_UNIT_MACROS_SVH
`define RIGID_POSE_QUATERNION_UNIT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent
`define RPQ_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("rpq: check failed");

// Check that the consequent holds in the cycle after the antecedent
`define RPQ_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("rpq: check failed");

`endif

// ===== hw/rtl/rpq_pkg.sv =====
// ----------------------------------------------------------------------------
// Rigid pose quaternion unit - package
// Widths, operation codes, sequencer phases and the quaternion product table.
// ----------------------------------------------------------------------------
package rpq_pkg;

    // Datapath widths
    localparam int AW    = 36;          // multiplier operand A (vector or partial)
    localparam int BW    = 17;          // multiplier operand B (quaternion term)
    localparam int PW    = AW + BW;     // full product
    localparam int SHIFT = 14;          // Q2.14 scaling
    localparam int ACCW  = 56;          // accumulator
    localparam int RW    = ACCW - SHIFT; // scaled accumulator result
    localparam int SW    = RW + 2;      // translation sum

    typedef enum logic [1:0] {
        OP_LOAD    = 2'd0,
        OP_COMPOSE = 2'd1,
        OP_INVERT  = 2'd2,
        OP_XFORM   = 2'd3
    } t_op;

    // Passes of the shared multiply-accumulate unit
    typedef enum logic [1:0] {
        PH_QQ  = 2'd0,   // reference rotation times input rotation
        PH_RV1 = 2'd1,   // rotation quaternion times vector
        PH_RV2 = 2'd2    // partial product times conjugate
    } t_phase;

    // Term issued to the multiply-accumulate unit
    typedef struct packed {
        logic       vld;
        logic       neg;
        logic       first;
        logic       last;
        logic [1:0] comp;
        t_phase     phase;
    } t_mac_issue;

    // Finished component leaving the multiply-accumulate unit
    typedef struct packed {
        logic       vld;
        logic [1:0] comp;
        t_phase     phase;
    } t_mac_wr;

    // Quaternion product r = a*b: step = comp*4 + term.
    // Left operand index per step; right operand index is (term - 1) mod 4.
    localparam logic [15:0][1:0] TERM_A = {
        2'd2, 2'd1, 2'd0, 2'd3,
        2'd3, 2'd0, 2'd1, 2'd2,
        2'd0, 2'd3, 2'd2, 2'd1,
        2'd1, 2'd2, 2'd3, 2'd0
    };

    // Terms that are subtracted
    localparam logic [15:0] TERM_NEG = 16'b1110_0010_1000_0100;

endpackage

// ===== hw/rtl/rigid_pose_quaternion_unit.sv =====
// ----------------------------------------------------------------------------
// Rigid pose quaternion unit - top level
// Fixed-point pose arithmetic: reference load, pose composition, pose
// inversion and point transform, all on one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
//   channel  | valid        | stall        | payload
//   ---------+--------------+--------------+------------------------------------
//   input    | i_in_valid   | o_in_stall   | i_op, i_rot_x..w, i_pos_x..z
//   output   | o_out_valid  | i_out_stall  | o_out_rot_x..w, o_out_pos_x..z,
//            |              |              | o_saturated
//
// A load transaction completes in its acceptance cycle and gives no result.
// Compose runs the rotation pass and then the vector passes, invert or
// transform only the vector passes: one 36x17 product per cycle through the
// shared multiplier while a pass runs, with a pipeline drain between passes.
// The input stalls while a transaction runs; a finished result waits in the
// output register. Reset sets the reference to the identity pose.
// ----------------------------------------------------------------------------
`include "rigid_pose_quaternion_unit_macros.svh"

module rigid_pose_quaternion_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_op,
    input  logic signed [15:0] i_rot_x,
    input  logic signed [15:0] i_rot_y,
    input  logic signed [15:0] i_rot_z,
    input  logic signed [15:0] i_rot_w,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [15:0] o_out_rot_x,
    output logic signed [15:0] o_out_rot_y,
    output logic signed [15:0] o_out_rot_z,
    output logic signed [15:0] o_out_rot_w,
    output logic signed [31:0] o_out_pos_x,
    output logic signed [31:0] o_out_pos_y,
    output logic signed [31:0] o_out_pos_z,
    output logic               o_saturated
);

    localparam int AW = rpq_pkg::AW;
    localparam int BW = rpq_pkg::BW;
    localparam int RW = rpq_pkg::RW;
    localparam int SW = rpq_pkg::SW;

    localparam logic signed [15:0] ROT_MAX = 16'sh7fff;
    localparam logic signed [15:0] ROT_MIN = 16'sh8000;
    localparam logic signed [31:0] POS_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] POS_MIN = 32'sh8000_0000;
    localparam logic signed [15:0] ROT_ONE = 16'sd16384;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_DRAIN,
        S_DONE
    } t_state;

    t_state                  r_state;
    rpq_pkg::t_phase         r_phase;
    rpq_pkg::t_op            r_op;
    logic [3:0]              r_step;

    logic signed [15:0]      r_q    [4];
    logic signed [31:0]      r_p    [3];
    logic signed [15:0]      r_rq   [4];
    logic signed [31:0]      r_rp   [3];
    logic signed [AW-1:0]    r_t    [4];
    logic signed [15:0]      r_orot [4];
    logic signed [31:0]      r_opos [3];
    logic                    r_sat;

    logic                    r_out_valid;
    logic signed [15:0]      r_out_rot [4];
    logic signed [31:0]      r_out_pos [3];
    logic                    r_out_sat;

    logic                    w_accept;
    logic                    w_in_sat;
    logic [1:0]              w_a_idx;
    logic [1:0]              w_b_idx;
    logic [1:0]              w_q_idx;
    logic [1:0]              w_rq_idx;
    logic                    w_conj;
    logic signed [BW-1:0]    w_q_sel;
    logic signed [BW-1:0]    w_rq_sel;
    logic signed [BW-1:0]    w_qr;
    logic signed [BW-1:0]    w_cq;
    logic signed [AW-1:0]    w_p_sel;
    logic signed [AW-1:0]    w_op_a;
    logic signed [BW-1:0]    w_op_b;
    logic                    w_last_step;
    rpq_pkg::t_mac_issue     w_issue;
    rpq_pkg::t_mac_wr        w_wr;
    logic signed [RW-1:0]    w_res;
    logic                    w_busy;
    logic signed [31:0]      w_rp_sel;
    logic signed [SW-1:0]    w_pos_sum;
    logic                    w_rot_ovf;
    logic signed [15:0]      w_rot_clamp;
    logic                    w_pos_ovf;
    logic signed [31:0]      w_pos_clamp;

    assign w_accept   = i_in_valid & (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);

    // Conjugate of the most negative component does not fit: flag it
    assign w_in_sat = (i_rot_x == ROT_MIN) | (i_rot_y == ROT_MIN) | (i_rot_z == ROT_MIN);

    // Term indices for the current step
    assign w_a_idx  = rpq_pkg::TERM_A[r_step];
    assign w_b_idx  = r_step[1:0] - 2'd1;
    assign w_q_idx  = (r_phase == rpq_pkg::PH_RV1) ? w_a_idx : w_b_idx;
    assign w_rq_idx = (r_phase == rpq_pkg::PH_RV2) ? w_b_idx : w_a_idx;

    // Rotation quaternion of the vector pass and its conjugate
    assign w_q_sel  = BW'(r_q[w_q_idx]);
    assign w_rq_sel = BW'(r_rq[w_rq_idx]);
    assign w_conj   = (w_q_idx != 2'd3);
    assign w_qr     = (r_op == rpq_pkg::OP_INVERT) ? (w_conj ? -w_q_sel : w_q_sel) : w_rq_sel;
    assign w_cq     = w_conj ? -w_qr : w_qr;

    // Vector operand, with a zero scalar part
    always_comb begin
        case (w_b_idx)
            2'd0:    w_p_sel = AW'(r_p[0]);
            2'd1:    w_p_sel = AW'(r_p[1]);
            2'd2:    w_p_sel = AW'(r_p[2]);
            default: w_p_sel = '0;
        endcase
    end

    // Route operands to the shared multiplier
    always_comb begin
        unique case (r_phase)
            rpq_pkg::PH_QQ: begin
                w_op_a = AW'(r_rq[w_rq_idx]);
                w_op_b = w_q_sel;
            end
            rpq_pkg::PH_RV1: begin
                w_op_a = w_p_sel;
                w_op_b = w_qr;
            end
            rpq_pkg::PH_RV2: begin
                w_op_a = r_t[w_a_idx];
                w_op_b = w_cq;
            end
            default: begin
                w_op_a = '0;
                w_op_b = '0;
            end
        endcase
    end

    // Issue one term per cycle while running
    assign w_last_step   = (r_phase == rpq_pkg::PH_RV2) ? (r_step == 4'd11) : (r_step == 4'd15);
    assign w_issue.vld   = (r_state == S_RUN);
    assign w_issue.neg   = rpq_pkg::TERM_NEG[r_step];
    assign w_issue.first = (r_step[1:0] == 2'd0);
    assign w_issue.last  = (r_step[1:0] == 2'd3);
    assign w_issue.comp  = r_step[3:2];
    assign w_issue.phase = r_phase;

    rpq_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_issue (w_issue),
        .i_a     (w_op_a),
        .i_b     (w_op_b),
        .o_wr    (w_wr),
        .o_res   (w_res),
        .o_busy  (w_busy)
    );

    // Clamp a composed rotation component
    assign w_rot_ovf   = (w_res > RW'(ROT_MAX)) | (w_res < RW'(ROT_MIN));
    assign w_rot_clamp = w_rot_ovf ? (w_res[RW-1] ? ROT_MIN : ROT_MAX) : w_res[15:0];

    // Form and clamp a translation component
    always_comb begin
        case (w_wr.comp)
            2'd0:    w_rp_sel = r_rp[0];
            2'd1:    w_rp_sel = r_rp[1];
            2'd2:    w_rp_sel = r_rp[2];
            default: w_rp_sel = '0;
        endcase
    end

    assign w_pos_sum   = (r_op == rpq_pkg::OP_INVERT) ? -SW'(w_res) : SW'(w_res) + SW'(w_rp_sel);
    assign w_pos_ovf   = (w_pos_sum > SW'(POS_MAX)) | (w_pos_sum < SW'(POS_MIN));
    assign w_pos_clamp = w_pos_ovf ? (w_pos_sum[SW-1] ? POS_MIN : POS_MAX) : w_pos_sum[31:0];

    // Sequencer, pose state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase     <= rpq_pkg::PH_QQ;
            r_op        <= rpq_pkg::OP_LOAD;
            r_step      <= '0;
            r_out_valid <= 1'b0;
            r_rq[0]     <= '0;
            r_rq[1]     <= '0;
            r_rq[2]     <= '0;
            r_rq[3]     <= ROT_ONE;
            r_rp[0]     <= '0;
            r_rp[1]     <= '0;
            r_rp[2]     <= '0;
        end else begin
            // Drop the output once taken
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            // Write back a finished component
            if (w_wr.vld) begin
                case (w_wr.phase)
                    rpq_pkg::PH_QQ: begin
                        r_orot[w_wr.comp] <= w_rot_clamp;
                        if (w_rot_ovf) begin
                            r_sat <= 1'b1;
                        end
                    end
                    rpq_pkg::PH_RV1: begin
                        r_t[w_wr.comp] <= w_res[AW-1:0];
                    end
                    default: begin
                        case (w_wr.comp)
                            2'd0:    r_opos[0] <= w_pos_clamp;
                            2'd1:    r_opos[1] <= w_pos_clamp;
                            default: r_opos[2] <= w_pos_clamp;
                        endcase
                        if (w_pos_ovf) begin
                            r_sat <= 1'b1;
                        end
                    end
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op   <= rpq_pkg::t_op'(i_op);
                        r_step <= '0;
                        r_q[0] <= i_rot_x;
                        r_q[1] <= i_rot_y;
                        r_q[2] <= i_rot_z;
                        r_q[3] <= i_rot_w;
                        r_p[0] <= i_pos_x;
                        r_p[1] <= i_pos_y;
                        r_p[2] <= i_pos_z;
                        unique case (rpq_pkg::t_op'(i_op))
                            rpq_pkg::OP_LOAD: begin
                                r_rq[0] <= i_rot_x;
                                r_rq[1] <= i_rot_y;
                                r_rq[2] <= i_rot_z;
                                r_rq[3] <= i_rot_w;
                                r_rp[0] <= i_pos_x;
                                r_rp[1] <= i_pos_y;
                                r_rp[2] <= i_pos_z;
                            end
                            rpq_pkg::OP_COMPOSE: begin
                                r_state <= S_RUN;
                                r_phase <= rpq_pkg::PH_QQ;
                                r_sat   <= 1'b0;
                            end
                            rpq_pkg::OP_INVERT: begin
                                r_state   <= S_RUN;
                                r_phase   <= rpq_pkg::PH_RV1;
                                r_sat     <= w_in_sat;
                                r_orot[0] <= (i_rot_x == ROT_MIN) ? ROT_MAX : -i_rot_x;
                                r_orot[1] <= (i_rot_y == ROT_MIN) ? ROT_MAX : -i_rot_y;
                                r_orot[2] <= (i_rot_z == ROT_MIN) ? ROT_MAX : -i_rot_z;
                                r_orot[3] <= i_rot_w;
                            end
                            default: begin
                                r_state   <= S_RUN;
                                r_phase   <= rpq_pkg::PH_RV1;
                                r_sat     <= 1'b0;
                                r_orot[0] <= r_rq[0];
                                r_orot[1] <= r_rq[1];
                                r_orot[2] <= r_rq[2];
                                r_orot[3] <= r_rq[3];
                            end
                        endcase
                    end
                end
                S_RUN: begin
                    // Advance through the terms of this pass
                    if (w_last_step) begin
                        r_step  <= '0;
                        r_state <= S_DRAIN;
                    end else begin
                        r_step <= r_step + 4'd1;
                    end
                end
                S_DRAIN: begin
                    // Hold until the last component is written back
                    if (!w_busy) begin
                        unique case (r_phase)
                            rpq_pkg::PH_QQ: begin
                                r_phase <= rpq_pkg::PH_RV1;
                                r_state <= S_RUN;
                            end
                            rpq_pkg::PH_RV1: begin
                                r_phase <= rpq_pkg::PH_RV2;
                                r_state <= S_RUN;
                            end
                            default: begin
                                r_state <= S_DONE;
                            end
                        endcase
                    end
                end
                S_DONE: begin
                    // Load the output register once it is free
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid  <= 1'b1;
                        r_out_rot[0] <= r_orot[0];
                        r_out_rot[1] <= r_orot[1];
                        r_out_rot[2] <= r_orot[2];
                        r_out_rot[3] <= r_orot[3];
                        r_out_pos[0] <= r_opos[0];
                        r_out_pos[1] <= r_opos[1];
                        r_out_pos[2] <= r_opos[2];
                        r_out_sat    <= r_sat;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rot_x = r_out_rot[0];
    assign o_out_rot_y = r_out_rot[1];
    assign o_out_rot_z = r_out_rot[2];
    assign o_out_rot_w = r_out_rot[3];
    assign o_out_pos_x = r_out_pos[0];
    assign o_out_pos_y = r_out_pos[1];
    assign o_out_pos_z = r_out_pos[2];
    assign o_saturated = r_out_sat;

    // Write-backs only happen while a transaction is in flight
    `RPQ_ASSERT_IMP(a_wr_in_flight, w_wr.vld, (r_state == S_RUN) || (r_state == S_DRAIN))

    // The pipeline is empty once all passes are finished
    `RPQ_ASSERT_IMP(a_done_drained, r_state == S_DONE, !w_busy)

    // A reference load completes in its acceptance cycle
    `RPQ_ASSERT_NXT(a_load_single, w_accept && (i_op == rpq_pkg::OP_LOAD), r_state == S_IDLE)

endmodule

// ===== hw/rtl/rpq_mac.sv =====
// ----------------------------------------------------------------------------
// Rigid pose quaternion unit - multiply-accumulate
// Shared signed multiplier with a registered product and a four-term
// accumulator; returns the sum shifted right arithmetically by 14.
// ----------------------------------------------------------------------------
module rpq_mac (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  rpq_pkg::t_mac_issue                  i_issue,
    input  logic signed [rpq_pkg::AW-1:0]        i_a,
    input  logic signed [rpq_pkg::BW-1:0]        i_b,
    output rpq_pkg::t_mac_wr                     o_wr,
    output logic signed [rpq_pkg::RW-1:0]        o_res,
    output logic                                 o_busy
);

    localparam int PW   = rpq_pkg::PW;
    localparam int ACCW = rpq_pkg::ACCW;

    rpq_pkg::t_mac_issue          r_ctl1;
    rpq_pkg::t_mac_wr             r_ctl2;
    logic signed [PW-1:0]         r_prod;
    logic signed [ACCW-1:0]       r_acc;

    logic signed [PW-1:0]         w_prod;
    logic signed [ACCW-1:0]       w_ext;
    logic signed [ACCW-1:0]       w_term;
    logic signed [ACCW-1:0]       w_base;

    // Form the product of the issued operands
    assign w_prod = i_a * i_b;

    // Sign the registered product and pick the running sum
    assign w_ext  = ACCW'(r_prod);
    assign w_term = r_ctl1.neg ? -w_ext : w_ext;
    assign w_base = r_ctl1.first ? '0 : r_acc;

    // Control pipeline
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1 <= '0;
            r_ctl2 <= '0;
        end else begin
            r_ctl1     <= i_issue;
            r_ctl2.vld <= r_ctl1.vld & r_ctl1.last;
            r_ctl2.comp  <= r_ctl1.comp;
            r_ctl2.phase <= r_ctl1.phase;
        end
    end

    // Product and accumulator
    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        if (r_ctl1.vld) begin
            r_acc <= w_base + w_term;
        end
    end

    assign o_wr   = r_ctl2;
    assign o_res  = $signed(r_acc[ACCW-1:rpq_pkg::SHIFT]);
    assign o_busy = r_ctl1.vld | r_ctl2.vld;

endmodule
